>>> rtl/core/sbdt_pkg.sv
package sbdt_pkg;

	localparam int MAX_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
	localparam int NUM_W      = 64;
	localparam int BIT_CNT_W  = 6;
	localparam int DCNT_W     = 5;
	localparam int POS_W      = 5;
	localparam int CAP_W      = 6;
	localparam int CODE_W     = 8;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 6'd32;
	localparam logic [CODE_W-1:0] CODE_ZERO  = 8'd48;
	localparam logic [CODE_W-1:0] CODE_NINE  = 8'd57;
	localparam logic [CODE_W-1:0] CODE_MINUS = 8'd45;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

>>> rtl/core/signed_binary_to_decimal_text_top.sv
// Signed 64-bit integer to ASCII decimal text.
// Input channel: in_valid / in_stall with number_value. One item is taken at
// a time; in_stall is high while a number is being converted or its text is
// still being handed out, and drops as the last character enters the output
// register, so the next number can be taken while that character waits.
// Output channel: out_valid / out_stall with char_code, char_position and
// is_last, one character per item, minus sign first, most significant digit
// next. The text is cut to output_capacity characters (capacity zero gives
// nothing); is_last marks the final character handed out.
// Configuration: cfg_write / cfg_data write output_capacity.
// Conversion: shift-and-add-3 (one magnitude bit per cycle), then leading
// zero digits dropped one at a time (up to 19), then one character per
// cycle while the receiver does not stall. Dropped zeros and digits together
// fill 20 digit slots. Capacity zero ends a number after conversion with no
// text, and a cut capacity ends the text earlier. The converter is bit-serial.
// A stalled receiver holds the output register and the emitter waits.
// Reset clears the control state, empties the output register and sets the
// capacity to 32.
module signed_binary_to_decimal_text_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sbdt_pkg::NUM_W-1:0]    number_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sbdt_pkg::CODE_W-1:0]   char_code,
	output logic [sbdt_pkg::POS_W-1:0]    char_position,
	output logic                          is_last,
	input  logic                          cfg_write,
	input  logic [sbdt_pkg::CAP_W-1:0]    cfg_data
);
	import sbdt_pkg::*;

	state_t                 state_q;
	logic [CAP_W-1:0]       cap_q;
	logic [NUM_W-1:0]       mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DCNT_W-1:0]      digits_left_q;
	logic [POS_W-1:0]       pos_q;
	logic                   sign_pending_q;
	logic                   out_valid_q;
	logic [CODE_W-1:0]      char_code_q;
	logic [POS_W-1:0]       char_position_q;
	logic                   is_last_q;
	logic                   in_accept;
	logic                   load;
	logic                   cap_hit;
	logic                   last_char;
	logic [DIGIT_W-1:0]     top_digit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];

	// Output register takes a new character when empty or being drained.
	assign load    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign cap_hit = (({1'b0, pos_q} + CAP_W'(1)) == cap_q);
	// The sign is never the final character of the full text.
	assign last_char = cap_hit || (!sign_pending_q && (digits_left_q == DCNT_W'(1)));

	// Add 3 to every BCD digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write) begin
			cap_q <= cfg_data;
		end
	end

	// Sequencer: convert, drop leading zeros, hand out characters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == BIT_CNT_W'(NUM_W - 1)) begin
						if (cap_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SKIP;
						end
					end
				end
				ST_SKIP: begin
					if (top_digit != '0 || digits_left_q == DCNT_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load && last_char) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			// Two's complement negate in unsigned arithmetic; the most
			// negative value maps onto its own bit pattern as 2^63.
			mag_q          <= number_value[NUM_W-1] ? (~number_value + NUM_W'(1))
			                                        : number_value;
			sign_pending_q <= number_value[NUM_W-1];
			bcd_q          <= '0;
			bit_cnt_q      <= '0;
			digits_left_q  <= DCNT_W'(MAX_DIGITS);
			pos_q          <= '0;
		end else begin
			unique case (state_q)
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BCD_W-2:0], mag_q[NUM_W-1]};
					mag_q     <= {mag_q[NUM_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
				end
				ST_SKIP: begin
					if (top_digit == '0 && digits_left_q != DCNT_W'(1)) begin
						bcd_q         <= {bcd_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
						digits_left_q <= digits_left_q - DCNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (load) begin
						pos_q <= pos_q + POS_W'(1);
						if (sign_pending_q) begin
							sign_pending_q <= 1'b0;
						end else begin
							bcd_q         <= {bcd_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
							digits_left_q <= digits_left_q - DCNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: hold while stalled, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_code_q     <= sign_pending_q ? CODE_MINUS
			                                  : (CODE_ZERO + CODE_W'(top_digit));
			char_position_q <= pos_q;
			is_last_q       <= last_char;
		end
	end

	assign out_valid     = out_valid_q;
	assign char_code     = char_code_q;
	assign char_position = char_position_q;
	assign is_last       = is_last_q;

`ifndef SYNTH
	a_skip_keeps_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SKIP |-> digits_left_q != '0)
		else $error("leading zero skip ran out of digits");

	a_emit_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> {1'b0, pos_q} < cap_q)
		else $error("emitter past capacity");

	a_conv_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && bit_cnt_q == BIT_CNT_W'(NUM_W - 1)) |=> state_q != ST_CONV)
		else $error("conversion overran 64 bits");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_code_q != CODE_MINUS) |->
			(char_code_q >= CODE_ZERO && char_code_q <= CODE_NINE))
		else $error("character outside digit range");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import sbdt_pkg::*;

	localparam int SETTLE_CYCLES = 150;
	localparam int MAX_GAP       = 17;
	localparam int LONG_HOLD     = 600;
	localparam int HOLD_AT       = 120;   // accepted numbers before the long hold-off
	localparam int PHASE_ITEMS   = 30;
	localparam int REPORT_LIMIT  = 10;

	// One emitted character as the receiver sees it.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [POS_W-1:0]  pos;
		logic              last;
	} char_item_t;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic [NUM_W-1:0]  number_value  = '0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [CODE_W-1:0] char_code;
	logic [POS_W-1:0]  char_position;
	logic              is_last;
	logic              cfg_write     = 1'b0;
	logic [CAP_W-1:0]  cfg_data      = '0;

	logic [NUM_W-1:0]  pending_numbers[$];
	char_item_t        expected_chars[$];

	logic [CAP_W-1:0]  char_capacity = CAP_RESET;  // mirror of output_capacity
	bit                idling_on     = 1'b1;
	int                numbers_accepted;
	int                failures;
	int                tx_wait;
	int                rx_wait;
	int                rx_hold_left;
	bit                hold_done;
	bit                number_taken;
	char_item_t        got_char;
	char_item_t        want_char;

	signed_binary_to_decimal_text_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.number_value  (number_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.char_code     (char_code),
		.char_position (char_position),
		.is_last       (is_last),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Work out the decimal text of one accepted number and queue its characters,
	// cut to the current capacity.
	function automatic void predict_text(logic [NUM_W-1:0] value);
		logic             negative;
		logic [NUM_W-1:0] magnitude;
		logic [3:0]       digits[MAX_DIGITS];
		int               ndig;
		int               sign_len;
		int               limit;
		char_item_t       c;
		negative  = value[NUM_W-1];
		// two's complement negate also maps the most negative value onto its
		// unsigned magnitude
		magnitude = negative ? (~value + 64'd1) : value;
		ndig = 0;
		do begin
			digits[ndig] = 4'(magnitude % 64'd10);
			magnitude    = magnitude / 64'd10;
			ndig++;
		end while (magnitude != 0 && ndig < MAX_DIGITS);
		sign_len = negative ? 1 : 0;
		limit    = ndig + sign_len;
		if (int'(char_capacity) < limit)
			limit = int'(char_capacity);
		for (int k = 0; k < limit; k++) begin
			if (negative && k == 0)
				c.code = CODE_MINUS;
			else
				c.code = CODE_ZERO + {4'd0, digits[ndig - 1 - (k - sign_len)]};
			c.pos  = POS_W'(k);
			c.last = (k == limit - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic int draw_gap();
		return idling_on ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	// Random number: full-width patterns, values of a random digit length,
	// small values, powers of ten and one below them, and values near the range ends.
	function automatic logic [NUM_W-1:0] random_number();
		logic [NUM_W-1:0] scale;
		logic [NUM_W-1:0] v;
		int               kind;
		scale = 64'd1;
		repeat ($urandom_range(1, 18)) scale = scale * 64'd10;
		kind = $urandom_range(0, 4);
		case (kind)
			0: v = {$urandom, $urandom};
			1: v = {$urandom, $urandom} % scale;
			2: v = 64'($urandom_range(0, 20));
			3: v = scale - 64'($urandom_range(0, 1));
			default: v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2));
		endcase
		if (kind != 0 && $urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// Sender: hold each number until it is taken, then wait a drawn number of
	// cycles before offering the next one. Prediction happens on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			number_taken = in_valid && !in_stall;
			if (number_taken) begin
				predict_text(number_value);
				numbers_accepted++;
			end
			if (number_taken || !in_valid) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (pending_numbers.size() != 0) begin
					number_value <= pending_numbers.pop_front();
					in_valid     <= 1'b1;
					tx_wait       = draw_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall a drawn number of cycles after each character; once,
	// hold off for a long stretch so the block backs up into its input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
				out_stall    <= 1'b1;
			end else if (!hold_done && numbers_accepted >= HOLD_AT) begin
				hold_done    <= 1'b1;
				rx_hold_left <= LONG_HOLD;
				rx_wait       = 0;
				out_stall    <= 1'b1;
			end else if (out_valid && !out_stall) begin
				rx_wait   = draw_gap();
				out_stall <= (rx_wait != 0);
			end else if (rx_wait > 1) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				rx_wait   = 0;
				out_stall <= 1'b0;
			end
		end
	end

	// Checker: compare every accepted character with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_char = '{code: char_code, pos: char_position, last: is_last};
			if (expected_chars.size() == 0) begin
				if (failures < REPORT_LIMIT)
					$display("%0t: unexpected char code %0d pos %0d last %0b",
						$realtime, char_code, char_position, is_last);
				failures++;
			end else begin
				want_char = expected_chars.pop_front();
				if (got_char != want_char) begin
					if (failures < REPORT_LIMIT)
						$display({"%0t: char mismatch: expected code %0d pos %0d last %0b,",
							" got code %0d pos %0d last %0b"},
							$realtime, want_char.code, want_char.pos, want_char.last,
							got_char.code, got_char.pos, got_char.last);
					failures++;
				end
			end
		end
	end

	// Wait until every number is taken and every character has come, then
	// give the block time to finish numbers that produce no characters.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_write    <= 1'b1;
		cfg_data     <= value;
		char_capacity = value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	logic [CAP_W-1:0] phase_caps[12] = '{6'd63, 6'd0, 6'd1, 6'd20, 6'd19, 6'd2,
		6'd21, 6'd5, 6'd32, 6'd10, 6'd63, 6'd1};

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed numbers at the reset capacity: zero, single digits, digit
		// count boundaries, both range ends and alternating bit patterns.
		@(negedge clk);
		pending_numbers = '{64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99,
			-64'sd100, 64'd12345678, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'd999999999999999999, -64'sd999999999999999999,
			64'd1000000000000000000, -64'sd1000000000000000000,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'hFFFF_FFFF_FFFF_FFF6, 64'd1000000000, 64'd4294967295, -64'sd123};
		wait_drained();

		// Random phases over capacities from zero to the register maximum;
		// every third phase runs with no idling on either side.
		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			@(negedge clk);
			idling_on = (p % 3 != 2);
			repeat (PHASE_ITEMS) pending_numbers.push_back(random_number());
			wait_drained();
		end

		if (expected_chars.size() != 0) begin
			$display("%0d expected chars never arrived", expected_chars.size());
			failures += expected_chars.size();
		end
		if (failures == 0)
			$display("** signed_binary_to_decimal_text_top: PASSED **");
		else
			$display("** signed_binary_to_decimal_text_top: FAILED **");
		$finish;
	end

	initial begin
		#1_500_000;
		$display("timeout");
		$display("** signed_binary_to_decimal_text_top: FAILED **");
		$finish;
	end

endmodule

>>> signed_binary_to_decimal_text_top.f
rtl/core/sbdt_pkg.sv
rtl/core/signed_binary_to_decimal_text_top.sv
tb/tb_top.sv
